// ===== src/ags_pkg.sv =====
// shared types, register codes and the constant table for the adaptive gain scheduler
`default_nettype none
package ags_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_SCALE_AMOUNT    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ERROR_WIDTH     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FALLOFF_POWER   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RAMP_DURATION   = 2'd3;

  localparam int unsigned InDataW  = 152;
  localparam int unsigned OutDataW = 64;

  localparam logic [15:0] POWER_ONE = 16'd4096;
  localparam logic [15:0] POWER_TWO = 16'd8192;
  localparam logic [47:0] POW_CAP   = 48'hFFFF_FFFF_FFFF;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [24:0] ONE_Q16   = 25'h001_0000;

  typedef struct packed {
    logic [23:0] scale_amount;
    logic [30:0] error_width;
    logic [15:0] falloff_power;
    logic [31:0] ramp_duration_us;
  } cfg_t;

  // one classified joint request handed from front to back
  typedef struct packed {
    logic [32:0] mag;
    logic [31:0] kp_base;
    logic [31:0] kd_base;
    logic        new_cycle;
    logic [19:0] elapsed_us;
  } item_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bit_v;
    res = '0;
    rem = v;
    for (int k = 31; k >= 0; k--) begin
      bit_v = 64'd1 << (2 * k);
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // q2.30 constants 2^(2^-i), i = 1..16, entry i-1 in the low bits first
  function automatic logic [16*32-1:0] exp_table();
    logic [16*32-1:0] tab;
    logic [63:0]      c;
    tab = '0;
    c = isqrt64(64'd1 << 61);
    tab[31:0] = c[31:0];
    for (int k = 1; k < 16; k++) begin
      c = isqrt64(c << 30);
      tab[k*32 +: 32] = c[31:0];
    end
    return tab;
  endfunction

  localparam logic [16*32-1:0] EXP_TABLE = exp_table();

endpackage
`default_nettype wire

// ===== src/ags_fifo.sv =====
// two-entry request queue between front and back
`default_nettype none
module ags_fifo
  import ags_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output item_t      pop_item
);

  item_t       mem_r [2];
  logic        wptr_r;
  logic        rptr_r;
  logic [1:0]  count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_item  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== src/ags_front.sv =====
// front end: takes joint requests, forms the error magnitude, queues them
`default_nettype none
module ags_front
  import ags_pkg::*;
(
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [InDataW-1:0] in_tdata,
  input  wire logic               q_full,
  output logic                    q_push,
  output item_t                   q_item
);

  logic signed [32:0] diff;
  logic        [32:0] mag;

  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full;

  always_comb begin
    diff = $signed({in_tdata[31], in_tdata[31:0]}) - $signed({in_tdata[63], in_tdata[63:32]});
    mag  = diff[32] ? 33'(-diff) : 33'(diff);
    q_item.mag        = in_tdata[64] ? mag : 33'd0;
    q_item.kp_base    = in_tdata[96:65];
    q_item.kd_base    = in_tdata[128:97];
    q_item.new_cycle  = in_tdata[129];
    q_item.elapsed_us = in_tdata[149:130];
  end

endmodule
`default_nettype wire

// ===== src/ags_back.sv =====
// back end: sequencer over a shared divider, log and exp multipliers and a root unit
`default_nettype none
module ags_back
  import ags_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cfg_t                cfg,
  input  wire logic                q_valid,
  input  wire item_t               q_item,
  output logic                     q_pop,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_RAMP_DIV, S_RAMP_ADD, S_RATIO_INIT, S_RATIO_DIV, S_POW_SEL, S_POW_SQ,
    S_NORM, S_LOG, S_LOGMUL, S_EXP_PREP, S_EXP, S_EXP_SHIFT, S_SCALE_INIT,
    S_SCALE_DIV, S_SCALE_SET, S_BLEND, S_SQRT, S_KP, S_KD, S_OUT
  } state_t;

  state_t             state_r;
  logic [5:0]         cnt_r;
  logic [30:0]        ramp_r;
  logic [32:0]        mag_r;
  logic [31:0]        kp_r;
  logic [31:0]        kd_r;
  logic [49:0]        num_r;
  logic [48:0]        rem_r;
  logic [48:0]        den_r;
  logic [47:0]        x_r;
  logic [5:0]         msb_r;
  logic [30:0]        m_r;
  logic [15:0]        frac_r;
  logic signed [27:0] t_r;
  logic signed [5:0]  n_r;
  logic [30:0]        y_r;
  logic [24:0]        s_r;
  logic [31:0]        kp_cmd_r;
  logic [31:0]        kd_cmd_r;
  logic               out_valid_r;

  // restoring divide step
  logic [49:0] rem_sh;
  logic        div_ge;
  logic [48:0] rem_n;
  logic [49:0] num_n;

  // square root step
  logic [49:0] sq_bit;
  logic [49:0] sq_trial;

  logic [47:0]        ratio_cap;
  logic [63:0]        sq_prod;
  logic [61:0]        log_prod;
  logic [31:0]        log_sq;
  logic signed [22:0] log_v;
  logic signed [39:0] pow_prod;
  logic signed [11:0] n_w;
  logic [62:0]        exp_prod;
  logic [31:0]        exp_c;
  logic [63:0]        exp_res;
  logic signed [6:0]  n_ext;
  logic signed [6:0]  shamt;
  logic [50:0]        ramp_sum;
  logic [55:0]        blend_prod;
  logic [56:0]        kp_prod;
  logic [52:0]        kd_prod;

  always_comb begin
    rem_sh   = {rem_r, num_r[49]};
    div_ge   = rem_sh >= {1'b0, den_r};
    rem_n    = div_ge ? 49'(rem_sh - {1'b0, den_r}) : rem_sh[48:0];
    num_n    = {num_r[48:0], div_ge};

    sq_bit   = 50'd1 << {cnt_r[4:0], 1'b0};
    sq_trial = {1'b0, rem_r} + sq_bit;

    ratio_cap = (num_r > {2'b00, POW_CAP}) ? POW_CAP : num_r[47:0];
    sq_prod   = x_r[31:0] * x_r[31:0];
    log_prod  = m_r * m_r;
    log_sq    = log_prod[61:30];
    log_v     = {7'({1'b0, msb_r} - 7'd16), frac_r};
    pow_prod  = log_v * $signed({1'b0, cfg.falloff_power});
    n_w       = t_r[27:16];
    exp_c     = EXP_TABLE[cnt_r[3:0]*32 +: 32];
    exp_prod  = y_r * exp_c[30:0];
    n_ext     = {n_r[5], n_r};
    shamt     = (n_r >= 6'sd14) ? (n_ext - 7'sd14) : (7'sd14 - n_ext);
    exp_res   = (n_r >= 6'sd14) ? ({33'd0, y_r} << shamt[4:0]) : ({33'd0, y_r} >> shamt[5:0]);
    ramp_sum  = {20'd0, ramp_r} + {1'b0, num_r};
    blend_prod = (s_r - ONE_Q16) * ramp_r;
    kp_prod   = kp_r * s_r;
    kd_prod   = kd_r * rem_r[20:0];
  end

  assign q_pop      = q_valid && (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {kd_cmd_r, kp_cmd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ramp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result loaded in S_OUT keeps valid high
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            mag_r <= q_item.mag;
            kp_r  <= q_item.kp_base;
            kd_r  <= q_item.kd_base;
            if (q_item.new_cycle && cfg.ramp_duration_us != 32'd0) begin
              num_r   <= {q_item.elapsed_us, 30'd0};
              den_r   <= {17'd0, cfg.ramp_duration_us};
              rem_r   <= '0;
              cnt_r   <= '0;
              state_r <= S_RAMP_DIV;
            end else begin
              if (q_item.new_cycle) begin
                ramp_r <= ONE_Q30;
              end
              state_r <= S_RATIO_INIT;
            end
          end
        end
        S_RAMP_DIV: begin
          rem_r <= rem_n;
          num_r <= num_n;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd49) begin
            state_r <= S_RAMP_ADD;
          end
        end
        S_RAMP_ADD: begin
          ramp_r  <= (ramp_sum > {20'd0, ONE_Q30}) ? ONE_Q30 : ramp_sum[30:0];
          state_r <= S_RATIO_INIT;
        end
        S_RATIO_INIT: begin
          if (cfg.scale_amount == 24'd0) begin
            s_r     <= ONE_Q16;
            state_r <= S_BLEND;
          end else begin
            num_r   <= {1'b0, mag_r, 16'd0};
            den_r   <= {18'd0, cfg.error_width};
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_RATIO_DIV;
          end
        end
        S_RATIO_DIV: begin
          rem_r <= rem_n;
          num_r <= num_n;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd49) begin
            state_r <= S_POW_SEL;
          end
        end
        S_POW_SEL: begin
          cnt_r <= '0;
          if (ratio_cap == 48'd0 || cfg.falloff_power == POWER_ONE) begin
            x_r     <= ratio_cap;
            state_r <= S_SCALE_INIT;
          end else if (cfg.falloff_power == POWER_TWO) begin
            if (ratio_cap[47:32] != 16'd0) begin
              x_r     <= POW_CAP;
              state_r <= S_SCALE_INIT;
            end else begin
              x_r     <= ratio_cap;
              state_r <= S_POW_SQ;
            end
          end else begin
            x_r     <= ratio_cap;
            state_r <= S_NORM;
          end
        end
        S_POW_SQ: begin
          x_r     <= sq_prod[63:16];
          state_r <= S_SCALE_INIT;
        end
        S_NORM: begin
          if (x_r[47]) begin
            m_r     <= x_r[47:17];
            msb_r   <= 6'd47 - cnt_r;
            cnt_r   <= '0;
            frac_r  <= '0;
            state_r <= S_LOG;
          end else begin
            x_r   <= {x_r[46:0], 1'b0};
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_LOG: begin
          m_r    <= log_sq[31] ? log_sq[31:1] : log_sq[30:0];
          frac_r <= {frac_r[14:0], log_sq[31]};
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd15) begin
            state_r <= S_LOGMUL;
          end
        end
        S_LOGMUL: begin
          t_r     <= 28'(pow_prod >>> 12);
          state_r <= S_EXP_PREP;
        end
        S_EXP_PREP: begin
          cnt_r <= '0;
          if (n_w >= 12'sd32) begin
            x_r     <= POW_CAP;
            state_r <= S_SCALE_INIT;
          end else if (n_w < -12'sd30) begin
            x_r     <= '0;
            state_r <= S_SCALE_INIT;
          end else begin
            n_r     <= 6'(n_w);
            frac_r  <= t_r[15:0];
            y_r     <= ONE_Q30;
            state_r <= S_EXP;
          end
        end
        S_EXP: begin
          if (frac_r[15]) begin
            y_r <= exp_prod[60:30];
          end
          frac_r <= {frac_r[14:0], 1'b0};
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd15) begin
            state_r <= S_EXP_SHIFT;
          end
        end
        S_EXP_SHIFT: begin
          x_r     <= (exp_res > {16'd0, POW_CAP}) ? POW_CAP : exp_res[47:0];
          state_r <= S_SCALE_INIT;
        end
        S_SCALE_INIT: begin
          num_r   <= {10'd0, cfg.scale_amount, 16'd0};
          den_r   <= {1'b0, x_r} + 49'd65536;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_SCALE_DIV;
        end
        S_SCALE_DIV: begin
          rem_r <= rem_n;
          num_r <= num_n;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd49) begin
            state_r <= S_SCALE_SET;
          end
        end
        S_SCALE_SET: begin
          s_r     <= ONE_Q16 + num_r[24:0];
          state_r <= S_BLEND;
        end
        S_BLEND: begin
          s_r     <= ONE_Q16 + 25'(blend_prod >> 30);
          num_r   <= {9'd0, ONE_Q16 + 25'(blend_prod >> 30), 16'd0};
          rem_r   <= '0;
          cnt_r   <= 6'd21;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (num_r >= sq_trial) begin
            num_r <= num_r - sq_trial;
            rem_r <= 49'(({1'b0, rem_r} >> 1) + sq_bit);
          end else begin
            rem_r <= rem_r >> 1;
          end
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            state_r <= S_KP;
          end
        end
        S_KP: begin
          kp_r    <= (kp_prod[56:48] != 9'd0) ? 32'hFFFF_FFFF : kp_prod[47:16];
          state_r <= S_KD;
        end
        S_KD: begin
          kd_r    <= (kd_prod[52:48] != 5'd0) ? 32'hFFFF_FFFF : kd_prod[47:16];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            kp_cmd_r    <= kp_r;
            kd_cmd_r    <= kd_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/adaptive_gain_scheduler.sv =====
// adaptive gain scheduler: top level with register file, front, queue and back
// back-end passes: the shared 50-step divider (ramp, error ratio, scale), the
//   normalize, 16-step log, 16-step exp and 22-step root passes; a zero scale
//   amount skips the ratio, power and scale passes, and only a new cycle with a
//   nonzero ramp duration runs the ramp divide
// throughput: one request per back-end pass; two more wait in the queue
// reset: synchronous active-low rst_n clears ramp, queue, sequencer and output
//   valid, and loads the register defaults
`default_nettype none
module adaptive_gain_scheduler
  import ags_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // target_position, measured_position, error_valid, kp_base, kd_base,
  // new_cycle, elapsed_us, two zero pad bits
  input  wire logic [InDataW-1:0]   in_tdata,
  // result channel
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // kp_command, kd_command
  output logic [OutDataW-1:0]       out_tdata,
  // register writes
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  cfg_t  cfg_r;
  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_valid;
  item_t q_in;
  item_t q_out;

  // register file; zero writes to error width and power are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_amount     <= 24'd0;
      cfg_r.error_width      <= 31'd52429;
      cfg_r.falloff_power    <= POWER_ONE;
      cfg_r.ramp_duration_us <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCALE_AMOUNT: begin
          cfg_r.scale_amount <= cfg_data[23:0];
        end
        CFG_ERROR_WIDTH: begin
          if (cfg_data[30:0] != 31'd0) begin
            cfg_r.error_width <= cfg_data[30:0];
          end
        end
        CFG_FALLOFF_POWER: begin
          if (cfg_data[15:0] != 16'd0) begin
            cfg_r.falloff_power <= cfg_data[15:0];
          end
        end
        CFG_RAMP_DURATION: begin
          cfg_r.ramp_duration_us <= cfg_data;
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // front: error magnitude and request classification
  ags_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  // queue decouples intake from the long arithmetic pass
  ags_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_out)
  );

  // back: ramp, ratio, power, scale, root and gain products
  ags_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== tb/adaptive_gain_scheduler_tb.sv =====
// self-checking testbench for the adaptive gain scheduler: directed and random joint requests
`default_nettype none
module adaptive_gain_scheduler_tb;
  import ags_pkg::*;

  localparam int unsigned WatchLimit = 40000;

  // request fields, lowest bits first
  typedef struct {
    logic [31:0] target;
    logic [31:0] measured;
    logic        err_ok;
    logic [31:0] kp;
    logic [31:0] kd;
    logic        cycle;
    logic [19:0] elapsed;
  } joint_t;

  typedef struct {
    logic [31:0] kp_cmd;
    logic [31:0] kd_cmd;
  } gains_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [InDataW-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  adaptive_gain_scheduler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and ramp
  logic [23:0] m_amount;
  logic [30:0] m_width;
  logic [15:0] m_power;
  logic [31:0] m_ramp_dur;
  logic [31:0] m_ramp;

  gains_t pending_gains[$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;     // receiver hold-off request, counted by the receiver
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res, rem, b;
    res = '0;
    rem = v;
    for (int k = 31; k >= 0; k--) begin
      b = 64'd1 << (2 * k);
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  function automatic longint log2_fix(input logic [63:0] r);
    int msb;
    logic [63:0] m, frac;
    msb = 63;
    while (r[msb] == 1'b0) msb--;
    m = (msb <= 30) ? (r << (30 - msb)) : (r >> (msb - 30));
    frac = '0;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[i] = 1'b1;
      end
    end
    return longint'(msb - 16) * 65536 + longint'(frac);
  endfunction

  function automatic logic [63:0] exp2_fix(input longint t);
    longint n;
    logic [63:0] f, y, c, res;
    n = (t >= 0) ? (t >>> 16) : -((-t + 65535) >>> 16);
    f = 64'(t - n * 65536);
    if (n >= 32) return 64'(POW_CAP);
    if (n < -30) return 64'd0;
    y = 64'd1 << 30;
    c = '0;
    for (int i = 1; i <= 16; i++) begin
      c = (i == 1) ? root64(64'd1 << 61) : root64(c << 30);
      if (f[16 - i]) y = (y * c) >> 30;
    end
    res = (n >= 14) ? (y << (n - 14)) : (y >> (14 - n));
    return (res > 64'(POW_CAP)) ? 64'(POW_CAP) : res;
  endfunction

  function automatic logic [63:0] falloff(input logic [63:0] r, input logic [15:0] p);
    longint prod, t;
    logic [63:0] sq;
    if (r == 0) return 64'd0;
    if (p == POWER_ONE) return r;
    if (p == POWER_TWO) begin
      if (r >= 64'h1_0000_0000) return 64'(POW_CAP);
      sq = (r * r) >> 16;
      return (sq > 64'(POW_CAP)) ? 64'(POW_CAP) : sq;
    end
    prod = log2_fix(r) * longint'(p);
    t = (prod >= 0) ? (prod >>> 12) : -((-prod + 4095) >>> 12);
    return exp2_fix(t);
  endfunction

  function automatic logic [31:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // advance the ramp and compute the scheduled gains for one joint
  function automatic gains_t schedule_gains(input joint_t j);
    gains_t g;
    logic [63:0] r, mag, ratio, den, scale, rt;
    longint d;
    if (j.cycle) begin
      if (m_ramp_dur == 0) begin
        m_ramp = 32'h4000_0000;
      end else begin
        r = 64'(m_ramp) + ((64'(j.elapsed) << 30) / 64'(m_ramp_dur));
        m_ramp = (r > 64'h4000_0000) ? 32'h4000_0000 : r[31:0];
      end
    end
    scale = 64'h1_0000;
    if (m_amount != 0) begin
      mag = '0;
      if (j.err_ok) begin
        d = longint'($signed(j.target)) - longint'($signed(j.measured));
        mag = 64'(d < 0 ? -d : d);
      end
      ratio = (mag << 16) / 64'(m_width);
      if (ratio > 64'(POW_CAP)) ratio = 64'(POW_CAP);
      den = falloff(ratio, m_power) + 64'h1_0000;
      scale = 64'h1_0000 + ((64'(m_amount) << 16) / den);
    end
    scale = 64'h1_0000 + (((scale - 64'h1_0000) * 64'(m_ramp)) >> 30);
    rt = root64(scale << 16);
    g.kp_cmd = clip32((64'(j.kp) * scale) >> 16);
    g.kd_cmd = clip32((64'(j.kd) * rt) >> 16);
    return g;
  endfunction

  // register write on the idle block, mirrored in the predictor
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SCALE_AMOUNT: begin
        m_amount = val[23:0];
      end
      CFG_ERROR_WIDTH: begin
        if (val[30:0] != 0) m_width = val[30:0];
      end
      CFG_FALLOFF_POWER: begin
        if (val[15:0] != 0) m_power = val[15:0];
      end
      default: begin
        m_ramp_dur = val;
      end
    endcase
  endtask

  // valid stays high between back-to-back requests, drops while the sender idles
  task automatic send_joint(input joint_t j);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= {2'b00, j.elapsed, j.cycle, j.kd, j.kp, j.err_ok, j.measured, j.target};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_gains.insert(pending_gains.size(), schedule_gains(j));
  endtask

  // wait for all results, then let the back end settle before a register write
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic joint_t rand_joint(input int width_hint);
    joint_t j;
    logic [31:0] off;
    j.target = $urandom();
    off = $urandom_range(width_hint);
    j.measured = ($urandom_range(9) == 0) ? $urandom()
               : j.target + (($urandom_range(1)) ? off : -off);
    j.err_ok = ($urandom_range(7) != 0);
    j.kp = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0100_0000);
    j.kd = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0010_0000);
    j.cycle = ($urandom_range(4) == 0);
    j.elapsed = $urandom_range(20'hFFFFF);
    if ($urandom_range(1)) j.elapsed = $urandom_range(5000);
    return j;
  endfunction

  // directed: field extremes, bypass, immediate ramp, ignored writes
  task automatic test_directed();
    joint_t j;
    j = '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 20'hFFFFF};
    send_joint(j);
    j = '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0, 32'h0, 1'b0, 20'h0};
    send_joint(j);
    drain();
    write_reg(CFG_SCALE_AMOUNT, 32'h00FF_FFFF);
    write_reg(CFG_ERROR_WIDTH, 32'h0);
    write_reg(CFG_FALLOFF_POWER, 32'h0);
    write_reg(CFG_RAMP_DURATION, 32'h0);
    j = '{32'h0, 32'h0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 20'h0};
    send_joint(j);  // ramp already one from the first request
    j.cycle = 1'b1;
    send_joint(j);  // zero duration jumps the ramp to one
    j = '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0001_0000, 32'h0001_0000, 1'b0, 20'h0};
    send_joint(j);  // huge ratio at unit power leaves the scale near one
    j = '{32'h0001_0000, 32'h0, 1'b1, 32'h0001_0000, 32'h0001_0000, 1'b0, 20'h0};
    send_joint(j);
    drain();
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_FALLOFF_POWER, (p == 0) ? POWER_TWO : (p == 1) ? 32'h0000_FFFF :
                (p == 2) ? 32'h1 : 32'h1_1800);  // top bits dropped
      write_reg(CFG_ERROR_WIDTH, (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'h1 : 32'd52429);
      for (int k = 0; k < 4; k++) send_joint(rand_joint(32'h0040_0000));
      drain();
    end
  endtask

  // random phases over several register settings
  task automatic test_random(input int count);
    int phase_len;
    phase_len = count / 6;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_SCALE_AMOUNT, (ph == 1) ? 32'h0 : (ph == 2) ? 32'h00FF_FFFF
                : $urandom_range(32'h0004_0000));
      write_reg(CFG_ERROR_WIDTH, $urandom_range(32'h0010_0000, 32'h100));
      write_reg(CFG_FALLOFF_POWER, (ph == 3) ? POWER_ONE : (ph == 4) ? POWER_TWO
                : $urandom_range(32'h0000_FFFF, 1));
      write_reg(CFG_RAMP_DURATION, (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(200000));
      if (ph == 0) send_idle_pct = 16;
      if (ph == 0) recv_idle_pct = 65;
      if (ph == 2) begin
        send_idle_pct = 65;
        recv_idle_pct = 16;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 5) hold_cycles = 1500;  // long hold-off fills the queue
      for (int k = 0; k < phase_len; k++) send_joint(rand_joint(32'h0020_0000));
      drain();
    end
  endtask

  // receiver ready with random stalls and requested hold-offs
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    gains_t g;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_gains.size() == 0) begin
        $error("unexpected result kp_command %h kd_command %h",
               out_tdata[31:0], out_tdata[63:32]);
        errors++;
      end else begin
        g = pending_gains.pop_front();
        if (out_tdata[31:0] !== g.kp_cmd) begin
          $error("kp_command expected %h actual %h", g.kp_cmd, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== g.kd_cmd) begin
          $error("kd_command expected %h actual %h", g.kd_cmd, out_tdata[63:32]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || pending_gains.size() == 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SCALE_AMOUNT;
    cfg_data <= '0;
    m_amount = '0;
    m_width = 31'd52429;
    m_power = POWER_ONE;
    m_ramp_dur = '0;
    m_ramp = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(900);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
